@@ rtl/core/tmtw_pkg.sv @@
// Shared types and constants for the text-mode terminal writer.
// No dependencies; imported by text_mode_terminal_writer_top.
package tmtw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam logic [7:0] RESET_ATTR   = 8'h0F;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam int CELL_W = 16;

  // Request codes; code 3 is unused and only echoes the cursor.
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_RD_MAP,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [4:0] pos_row;
    logic [6:0] pos_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } rsp_t;

endpackage

@@ rtl/core/tmtw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/text_mode_terminal_writer_top.sv @@
// Text-mode terminal writer top level: cell store, cursor, request sequencer.
// Depends on tmtw_pkg and tmtw_ram.
//
// A ROWS x COLS screen of 16-bit cells (attribute in bits 15:8, character in
// 7:0) kept in one RAM that is addressed as a ring of rows: a top-row pointer
// maps logical rows to physical rows, so a scroll moves no data and only
// blanks the evicted row, which becomes the new bottom row. On the request
// channel, a put (character or newline) that does not scroll keeps the
// sequencer in ST_IDLE, and puts can follow each other every cycle while
// the output queue has room; a put that scrolls then makes one RAM write per
// cell of the new bottom row; a read is mapped to its physical row when
// accepted, then steps through ST_RD_MAP, ST_RD_ADDR and ST_RD_DATA (RAM
// read); a clear writes every cell, one per cycle. After reset the block clears
// all ROWS*COLS cells (2000 at the default size) with req_ready low before it
// takes the first request. Results pass through a two-entry output queue,
// so a request can be taken while one finished result still waits on the
// response channel. The configuration channel is always ready; the new
// clear attribute is used by the next clear request.
module text_mode_terminal_writer_top #(
  parameter int ROWS = tmtw_pkg::ROWS_DEF,
  parameter int COLS = tmtw_pkg::COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tmtw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tmtw_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data
);

  import tmtw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(COLS - 1);
  localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);

  state_t state, state_next;

  // cursor: logical row/col, plus physical row and its base address
  logic [RW-1:0] row, prow, top;
  logic [CW-1:0] col;
  logic [AW-1:0] base;

  logic [7:0]    clear_attr;

  // fill sweep
  logic [AW-1:0] fill_addr, fill_last;
  logic [7:0]    fill_attr;

  // read pipeline
  logic [RW-1:0] rd_prow;
  logic [CW-1:0] rd_col;
  logic          rd_ok;

  // output queue, two entries
  rsp_t       q0, q1, q0_next, q1_next;
  logic [1:0] cnt, cnt_next;
  logic       push, pop;
  rsp_t       push_data;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic accept;

  // ---------------------------------------------------------------------
  // Put: cursor advance
  // ---------------------------------------------------------------------
  logic          is_nl, wrap, put_scroll;
  logic [RW-1:0] row_put, prow_adv, top_adv;
  logic [CW-1:0] col_put;
  logic [AW-1:0] base_adv;

  always_comb begin
    is_nl      = (req.char_code == NEWLINE_CHAR);
    wrap       = is_nl || (col == COL_LAST);
    col_put    = wrap ? '0 : CW'(col + 1'b1);
    put_scroll = wrap && (row == ROW_LAST);
    row_put    = (wrap && !put_scroll) ? RW'(row + 1'b1) : row;
    prow_adv   = (prow == ROW_LAST) ? '0 : RW'(prow + 1'b1);
    base_adv   = (prow == ROW_LAST) ? '0 : AW'(base + ROW_STEP);
    top_adv    = (top == ROW_LAST) ? '0 : RW'(top + 1'b1);
  end

  // ---------------------------------------------------------------------
  // Read: logical row to physical row (one compare and subtract)
  // ---------------------------------------------------------------------
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_prow_in;
  logic          rd_ok_in;

  always_comb begin
    rd_sum     = (RW + 1)'(req.read_row) + {1'b0, top};
    rd_prow_in = (rd_sum >= ROWS_EXT) ? RW'(rd_sum - ROWS_EXT) : RW'(rd_sum);
    rd_ok_in   = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLS);
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  assign accept = req_valid && req_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (fill_addr == fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_PUT:   state_next = put_scroll ? ST_FILL : ST_IDLE;
            REQ_READ:  state_next = ST_RD_MAP;
            REQ_CLEAR: state_next = ST_FILL;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_MAP:  state_next = ST_RD_ADDR;
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (RAM control, ready, result push)
  // ---------------------------------------------------------------------
  always_comb begin
    req_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fill_addr;
    ram_wdata = {fill_attr, SPACE_CHAR};
    ram_raddr = AW'(int'(rd_prow) * COLS + int'(rd_col));
    push      = 1'b0;
    push_data = '{pos_row: 5'(row), pos_col: 7'(col),
                  cell_char: '0, cell_attr: '0, scrolled: 1'b0};
    unique case (state)
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        req_ready = (cnt != 2'd2);
        if (accept) begin
          unique case (req.req_type)
            REQ_PUT: begin
              ram_we    = !is_nl;
              ram_waddr = AW'(base + AW'(col));
              ram_wdata = {req.attribute, req.char_code};
              push      = 1'b1;
              push_data.pos_row  = 5'(row_put);
              push_data.pos_col  = 7'(col_put);
              push_data.scrolled = put_scroll;
            end
            REQ_READ: ;
            REQ_CLEAR: begin
              push      = 1'b1;
              push_data.pos_row = '0;
              push_data.pos_col = '0;
            end
            default: push = 1'b1;
          endcase
        end
      end
      ST_RD_MAP, ST_RD_ADDR: ;
      ST_RD_DATA: begin
        push = 1'b1;
        if (rd_ok) begin
          push_data.cell_char = ram_rdata[7:0];
          push_data.cell_attr = ram_rdata[15:8];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      row        <= '0;
      col        <= '0;
      prow       <= '0;
      base       <= '0;
      top        <= '0;
      clear_attr <= RESET_ATTR;
      fill_addr  <= '0;
      fill_last  <= ADDR_LAST;
      fill_attr  <= RESET_ATTR;
      rd_prow    <= '0;
      rd_col     <= '0;
      rd_ok      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        clear_attr <= cfg_data;
      end
      if (state == ST_FILL) begin
        fill_addr <= AW'(fill_addr + 1'b1);
      end
      if (accept) begin
        unique case (req.req_type)
          REQ_PUT: begin
            row <= row_put;
            col <= col_put;
            if (wrap) begin
              prow <= prow_adv;
              base <= base_adv;
            end
            if (put_scroll) begin
              // new bottom row is the evicted top row; blank it
              top       <= top_adv;
              fill_addr <= base_adv;
              fill_last <= AW'(base_adv + ROW_SPAN);
              fill_attr <= req.attribute;
            end
          end
          REQ_READ: begin
            rd_prow <= rd_prow_in;
            rd_col  <= CW'(req.read_col);
            rd_ok   <= rd_ok_in;
          end
          REQ_CLEAR: begin
            row       <= '0;
            col       <= '0;
            prow      <= '0;
            base      <= '0;
            top       <= '0;
            fill_addr <= '0;
            fill_last <= ADDR_LAST;
            fill_attr <= clear_attr;
          end
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  assign rsp_valid = (cnt != 2'd0);
  assign rsp       = q0;
  assign pop       = rsp_valid && rsp_ready;

  always_comb begin
    q0_next  = q0;
    q1_next  = q1;
    cnt_next = cnt;
    if (pop) begin
      q0_next = q1;
    end
    if (push) begin
      if (cnt == 2'd0 || (cnt == 2'd1 && pop)) begin
        q0_next = push_data;
      end else begin
        q1_next = push_data;
      end
    end
    cnt_next = 2'(cnt + 2'(push) - 2'(pop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    q0 <= q0_next;
    q1 <= q1_next;
  end

  // ---------------------------------------------------------------------
  // Cell store
  // ---------------------------------------------------------------------
  tmtw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
